// ===== rtl/plgt_pkg.sv =====
// Shared constants, types and status codes of the gray-to-temperature converter.
package plgt_pkg;

	// Calibration table geometry
	localparam int POINTS = 50;
	localparam int AW     = $clog2(POINTS);

	// Field widths
	localparam int GW    = 16;   // gray level
	localparam int OW    = 24;   // Q.8 offsets and sensor temperature
	localparam int QW    = 32;   // result temperature
	localparam int ADJ_W = 26;   // gray*128 plus offset difference
	localparam int SG_W  = 19;   // adjusted gray before saturation
	localparam int A_W   = 25;   // segment*256 plus add offset
	localparam int DEN_W = 17;   // segment width, signed
	localparam int DM_W  = 16;   // segment width magnitude
	localparam int NUM_W = 42;   // interpolation numerator, signed
	localparam int MAG_W = 41;   // numerator magnitude
	localparam int CNT_W = $clog2(MAG_W + 1);

	typedef enum logic [1:0] {
		ST_IN_TABLE = 2'd0,
		ST_CLAMP_LO = 2'd1,
		ST_CLAMP_HI = 2'd2,
		ST_NO_SEG   = 2'd3
	} status_t;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	// Request into the serial divider
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [DM_W-1:0]  divisor;
	} div_req_t;

endpackage

// ===== rtl/plgt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plgt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 50
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/plgt_div.sv =====
// Serial restoring divider, one quotient bit per cycle, unsigned magnitudes.
module plgt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plgt_pkg::div_req_t         req,
	output logic [plgt_pkg::MAG_W-1:0] quotient,
	output logic                       done
);

	logic [plgt_pkg::CNT_W-1:0] cnt_q;
	logic [plgt_pkg::MAG_W-1:0] quot_q;
	logic [plgt_pkg::DM_W-1:0]  rem_q;
	logic [plgt_pkg::DM_W-1:0]  dvs_q;
	logic                       done_q;
	logic [plgt_pkg::DM_W:0]    shifted;
	logic [plgt_pkg::DM_W+1:0]  trial;
	logic                       fits;

	// Shift in the next dividend bit and try to subtract the divisor
	assign shifted = {rem_q, quot_q[plgt_pkg::MAG_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~trial[plgt_pkg::DM_W+1];

	// Control: count steps, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= plgt_pkg::CNT_W'(plgt_pkg::MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == plgt_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[plgt_pkg::MAG_W-2:0], fits};
			rem_q  <= fits ? trial[plgt_pkg::DM_W-1:0] : shifted[plgt_pkg::DM_W-1:0];
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

// ===== rtl/piecewise_linear_gray_to_temperature_core.sv =====
// Top level: calibration table, segment search sequencer and interpolation.
//
//  channel  direction  handshake          payload
//  in       to core    in_valid/in_stall  op, point_index, point_value, gray,
//                                         scene_offset, add_offset
//  out      from core  out_valid/out_stall temperature_q8, status
//  cfg      to core    cfg_valid/cfg_ready cfg_data (sensor_temp)
//
// A load request is taken without stalling the input. A convert request interpolates on
// the first segment when it holds the gray or the gray clamps below, on the last when it
// clamps above, else on the first segment that a scan finds, using a serial divider that
// forms 41 quotient bits; it gives zero when no segment fits or the segment has zero width.
// in_stall is high while a conversion is in progress or its result waits for the output
// register. Reset clears control state and sensor_temp; the calibration table holds no value
// until written.
module piecewise_linear_gray_to_temperature_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [5:0]                      point_index,
	input  logic signed [plgt_pkg::GW-1:0]  point_value,
	input  logic signed [plgt_pkg::GW-1:0]  gray,
	input  logic signed [plgt_pkg::OW-1:0]  scene_offset,
	input  logic signed [plgt_pkg::OW-1:0]  add_offset,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [plgt_pkg::QW-1:0]  temperature_q8,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic signed [plgt_pkg::OW-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_GOT0, S_GOT1, S_GOTN, S_WAITLO, S_GOTLO,
		S_SCAN, S_MUL, S_SUM, S_DIV, S_OUT
	} state_t;

	state_t                            state_q;
	logic signed [plgt_pkg::OW-1:0]    sensor_temp_q;
	logic signed [plgt_pkg::GW-1:0]    g_q;
	logic signed [plgt_pkg::OW-1:0]    add_q;
	logic signed [plgt_pkg::GW-1:0]    lo_q;
	logic signed [plgt_pkg::GW-1:0]    hi_q;
	logic [plgt_pkg::AW-1:0]           cur_q;
	logic [plgt_pkg::AW-1:0]           rd_addr_q;
	plgt_pkg::status_t                 stat_q;
	logic signed [plgt_pkg::NUM_W-1:0] prod_q;
	logic signed [plgt_pkg::DEN_W-1:0] den_q;
	logic                              qneg_q;
	logic signed [plgt_pkg::QW-1:0]    res_q;
	logic                              out_valid_q;
	logic signed [plgt_pkg::QW-1:0]    temp_out_q;
	plgt_pkg::status_t                 status_out_q;

	logic                              in_acc;
	logic                              ram_we;
	logic signed [plgt_pkg::GW-1:0]    rdata;
	logic signed [plgt_pkg::ADJ_W-1:0] adj;
	logic signed [plgt_pkg::ADJ_W-1:0] adj_rnd;
	logic signed [plgt_pkg::SG_W-1:0]  g_wide;
	logic signed [plgt_pkg::GW-1:0]    g_sat;
	logic signed [plgt_pkg::DEN_W-1:0] den;
	logic signed [plgt_pkg::A_W-1:0]   a_term;
	logic signed [plgt_pkg::NUM_W-1:0] prod;
	logic signed [plgt_pkg::DEN_W-1:0] gdiff;
	logic signed [plgt_pkg::NUM_W-1:0] num;
	logic [plgt_pkg::NUM_W-1:0]        num_abs;
	logic [plgt_pkg::DEN_W-1:0]        den_abs;
	plgt_pkg::div_req_t                div_req;
	logic [plgt_pkg::MAG_W-1:0]        quot;
	logic                              div_done;
	logic signed [plgt_pkg::QW-1:0]    q_sat;
	logic                              out_free;
	logic                              g_in_lo_rd;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = ~out_valid_q | ~out_stall;

	// Table write on an in-range load request
	assign ram_we = in_acc & (op == plgt_pkg::OP_LOAD) & (point_index < 6'(plgt_pkg::POINTS));

	plgt_ram #(
		.WIDTH(plgt_pkg::GW),
		.DEPTH(plgt_pkg::POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (plgt_pkg::AW'(point_index)),
		.wdata (point_value),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	// Adjust gray by twice the sensor/scene difference, truncate toward zero, saturate
	assign adj = (plgt_pkg::ADJ_W'(gray) <<< 7)
	           + plgt_pkg::ADJ_W'(sensor_temp_q) - plgt_pkg::ADJ_W'(scene_offset);
	assign adj_rnd = adj + (adj[plgt_pkg::ADJ_W-1] ? plgt_pkg::ADJ_W'(127) : '0);
	assign g_wide  = plgt_pkg::SG_W'(adj_rnd >>> 7);
	always_comb begin
		if (g_wide > plgt_pkg::SG_W'(32767)) begin
			g_sat = 16'sh7FFF;
		end else if (g_wide < -(plgt_pkg::SG_W'(32768))) begin
			g_sat = 16'sh8000;
		end else begin
			g_sat = plgt_pkg::GW'(g_wide);
		end
	end

	// Segment test against the entry being read
	assign g_in_lo_rd = (g_q >= lo_q) && (g_q <= rdata);

	// Interpolation numerator: (seg*256 + add)*den + (g - lo)*256
	assign den     = plgt_pkg::DEN_W'(hi_q) - plgt_pkg::DEN_W'(lo_q);
	assign a_term  = plgt_pkg::A_W'({cur_q, 8'h00}) + plgt_pkg::A_W'(add_q);
	assign prod    = plgt_pkg::NUM_W'(a_term) * plgt_pkg::NUM_W'(den);
	assign gdiff   = plgt_pkg::DEN_W'(g_q) - plgt_pkg::DEN_W'(lo_q);
	assign num     = prod_q + (plgt_pkg::NUM_W'(gdiff) <<< 8);
	assign num_abs = num[plgt_pkg::NUM_W-1] ? plgt_pkg::NUM_W'(-num) : plgt_pkg::NUM_W'(num);
	assign den_abs = den_q[plgt_pkg::DEN_W-1] ? plgt_pkg::DEN_W'(-den_q)
	                                           : plgt_pkg::DEN_W'(den_q);

	assign div_req.start    = (state_q == S_SUM);
	assign div_req.dividend = num_abs[plgt_pkg::MAG_W-1:0];
	assign div_req.divisor  = den_abs[plgt_pkg::DM_W-1:0];

	plgt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.quotient (quot),
		.done     (div_done)
	);

	// Apply the quotient sign and saturate to 32 bits
	always_comb begin
		if (qneg_q) begin
			if (quot > plgt_pkg::MAG_W'(64'h8000_0000)) begin
				q_sat = 32'sh8000_0000;
			end else begin
				q_sat = plgt_pkg::QW'(-quot);
			end
		end else begin
			if (quot > plgt_pkg::MAG_W'(64'h7FFF_FFFF)) begin
				q_sat = 32'sh7FFF_FFFF;
			end else begin
				q_sat = plgt_pkg::QW'(quot);
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_temp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			sensor_temp_q <= cfg_data;
		end
	end

	// Sequencer: segment search, multiply, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			rd_addr_q    <= '0;
			cur_q        <= '0;
			stat_q       <= plgt_pkg::ST_IN_TABLE;
			status_out_q <= plgt_pkg::ST_IN_TABLE;
		end else begin
			// raise valid on a new result, drop a delivered one
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && op == plgt_pkg::OP_CONVERT) begin
						g_q       <= g_sat;
						add_q     <= add_offset;
						rd_addr_q <= '0;
						state_q   <= S_RD0;
					end
				end
				S_RD0: begin
					rd_addr_q <= plgt_pkg::AW'(1);
					state_q   <= S_GOT0;
				end
				S_GOT0: begin
					lo_q      <= rdata;
					rd_addr_q <= plgt_pkg::AW'(plgt_pkg::POINTS - 1);
					state_q   <= S_GOT1;
				end
				S_GOT1: begin
					hi_q <= rdata;
					if (g_in_lo_rd) begin
						cur_q   <= '0;
						stat_q  <= plgt_pkg::ST_IN_TABLE;
						state_q <= S_MUL;
					end else if (g_q < lo_q) begin
						cur_q   <= '0;
						stat_q  <= plgt_pkg::ST_CLAMP_LO;
						state_q <= S_MUL;
					end else begin
						lo_q      <= rdata;
						rd_addr_q <= plgt_pkg::AW'(2);
						state_q   <= S_GOTN;
					end
				end
				S_GOTN: begin
					if (g_q > rdata) begin
						hi_q      <= rdata;
						cur_q     <= plgt_pkg::AW'(plgt_pkg::POINTS - 2);
						stat_q    <= plgt_pkg::ST_CLAMP_HI;
						rd_addr_q <= plgt_pkg::AW'(plgt_pkg::POINTS - 2);
						state_q   <= S_WAITLO;
					end else if (plgt_pkg::POINTS < 3) begin
						res_q   <= '0;
						stat_q  <= plgt_pkg::ST_NO_SEG;
						state_q <= S_OUT;
					end else begin
						cur_q     <= plgt_pkg::AW'(1);
						rd_addr_q <= plgt_pkg::AW'(3);
						state_q   <= S_SCAN;
					end
				end
				S_WAITLO: begin
					state_q <= S_GOTLO;
				end
				S_GOTLO: begin
					lo_q    <= rdata;
					state_q <= S_MUL;
				end
				S_SCAN: begin
					// lo_q holds entry cur, rdata holds entry cur+1
					if (g_in_lo_rd) begin
						hi_q    <= rdata;
						stat_q  <= plgt_pkg::ST_IN_TABLE;
						state_q <= S_MUL;
					end else if (cur_q == plgt_pkg::AW'(plgt_pkg::POINTS - 2)) begin
						res_q   <= '0;
						stat_q  <= plgt_pkg::ST_NO_SEG;
						state_q <= S_OUT;
					end else begin
						lo_q      <= rdata;
						cur_q     <= cur_q + 1'b1;
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				S_MUL: begin
					if (den == '0) begin
						res_q   <= '0;
						stat_q  <= plgt_pkg::ST_NO_SEG;
						state_q <= S_OUT;
					end else begin
						prod_q  <= prod;
						den_q   <= den;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					qneg_q  <= num[plgt_pkg::NUM_W-1] ^ den_q[plgt_pkg::DEN_W-1];
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= q_sat;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						temp_out_q   <= res_q;
						status_out_q <= stat_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature_q8 = temp_out_q;
	assign status         = status_out_q;

endmodule

// ===== test/tb.sv =====
// Testbench of the gray-to-temperature core: directed and random requests checked by a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plgt_pkg::*;

	localparam int SETTLE      = 128;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_REQS  = 160;
	localparam int GRAY_MIN    = -(1 << (GW - 1));
	localparam int GRAY_MAX    = (1 << (GW - 1)) - 1;
	localparam int OFS_MIN     = -(1 << (OW - 1));
	localparam int OFS_MAX     = (1 << (OW - 1)) - 1;

	typedef struct {
		logic                 op;
		logic [5:0]           idx;
		logic signed [GW-1:0] pval;
		logic signed [GW-1:0] gray;
		logic signed [OW-1:0] scene;
		logic signed [OW-1:0] add;
	} conv_req_t;

	typedef struct {
		logic signed [QW-1:0] temp;
		status_t              st;
	} temp_res_t;

	typedef struct {
		conv_req_t req;
		bit        fixed;
		temp_res_t res;
	} dir_row_t;

	typedef enum int {
		CURVE_BASELINE,
		CURVE_LINEAR,
		CURVE_FALLING,
		CURVE_STAIRS,
		CURVE_JAGGED,
		CURVE_FULL_SPAN,
		CURVE_FINE
	} curve_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 op;
	logic [5:0]           point_index;
	logic signed [GW-1:0] point_value;
	logic signed [GW-1:0] gray;
	logic signed [OW-1:0] scene_offset;
	logic signed [OW-1:0] add_offset;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [QW-1:0] temperature_q8;
	logic [1:0]           status;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic signed [OW-1:0] cfg_data;

	// local copy of the core state
	longint    cal_copy [POINTS];
	longint    sensor_copy = 0;
	temp_res_t expected_temps [$];
	int        mismatches = 0;
	bit        calm = 1'b0;

	piecewise_linear_gray_to_temperature_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.point_index    (point_index),
		.point_value    (point_value),
		.gray           (gray),
		.scene_offset   (scene_offset),
		.add_offset     (add_offset),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.temperature_q8 (temperature_q8),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Idle length: mostly none or short, now and then long; none at all in calm phases
	function automatic int gap_len();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Temperature and status that a convert request yields on the current table
	function automatic temp_res_t convert_temp(input conv_req_t r);
		temp_res_t res;
		longint    g, num2, den, q;
		int        seg, i;
		g = (longint'(r.gray) * 128 + sensor_copy - longint'(r.scene)) / 128;
		if (g > GRAY_MAX)
			g = GRAY_MAX;
		if (g < GRAY_MIN)
			g = GRAY_MIN;
		// pick the segment: first point pair, clamps, then first pair holding g
		seg = -1;
		res.st = ST_IN_TABLE;
		if (g >= cal_copy[0] && g <= cal_copy[1]) begin
			seg = 0;
		end else if (g < cal_copy[0]) begin
			seg = 0;
			res.st = ST_CLAMP_LO;
		end else if (g > cal_copy[POINTS-1]) begin
			seg = POINTS - 2;
			res.st = ST_CLAMP_HI;
		end else begin
			for (i = 1; i < POINTS - 1 && seg < 0; i++)
				if (g >= cal_copy[i] && g <= cal_copy[i+1])
					seg = i;
		end
		// interpolate exactly, truncate toward zero once
		q = 0;
		if (seg < 0) begin
			res.st = ST_NO_SEG;
		end else begin
			den = cal_copy[seg+1] - cal_copy[seg];
			if (den == 0) begin
				res.st = ST_NO_SEG;
			end else begin
				num2 = (longint'(seg) * 256 + longint'(r.add)) * den + (g - cal_copy[seg]) * 256;
				if (den < 0) begin
					den = -den;
					num2 = -num2;
				end
				q = num2 / den;
			end
		end
		if (q > longint'(2147483647))
			q = 2147483647;
		if (q < -longint'(2147483647) - 1)
			q = -longint'(2147483647) - 1;
		res.temp = q[QW-1:0];
		return res;
	endfunction

	function automatic dir_row_t mk_row(input logic o, input int idx, input int pval, input int g,
		input int scene, input int add, input bit fixed, input int t, input status_t st);
		dir_row_t row;
		row.req.op    = o;
		row.req.idx   = 6'(idx);
		row.req.pval  = GW'(pval);
		row.req.gray  = GW'(g);
		row.req.scene = OW'(scene);
		row.req.add   = OW'(add);
		row.fixed     = fixed;
		row.res.temp  = QW'(t);
		row.res.st    = st;
		return row;
	endfunction

	// Present one request, hold it until taken, and mirror it in the local copy
	task automatic send_req(input conv_req_t r, input bit fixed, input temp_res_t fixed_res);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op           <= r.op;
		point_index  <= r.idx;
		point_value  <= r.pval;
		gray         <= r.gray;
		scene_offset <= r.scene;
		add_offset   <= r.add;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (r.op == OP_LOAD) begin
			if (r.idx < POINTS)
				cal_copy[r.idx] = longint'(r.pval);
		end else if (fixed) begin
			expected_temps.push_back(fixed_res);
		end else begin
			expected_temps.push_back(convert_temp(r));
		end
		@(negedge clk);
	endtask

	// Fill the whole calibration table with one curve
	task automatic load_table(input curve_t kind);
		int        pts [POINTS];
		int        step, base, i;
		bit [31:0] rnd;
		conv_req_t r;
		temp_res_t none;
		none.temp = '0;
		none.st   = ST_IN_TABLE;
		step = (kind == CURVE_FINE) ? $urandom_range(1, 3) : $urandom_range(1, 1300);
		base = int'($urandom_range(0, 65535 - (POINTS - 1) * step)) + GRAY_MIN;
		for (i = 0; i < POINTS; i++) begin
			case (kind)
				CURVE_BASELINE: pts[i] = 100 * i;
				CURVE_LINEAR, CURVE_FINE: pts[i] = base + i * step;
				CURVE_FALLING: pts[i] = base + (POINTS - 1 - i) * step;
				CURVE_STAIRS: begin
					// rising steps with some flat ones
					if (i == 0)
						pts[i] = GRAY_MIN + int'($urandom_range(0, 4000));
					else if ($urandom_range(0, 9) == 0)
						pts[i] = pts[i-1];
					else
						pts[i] = clip(pts[i-1] + int'($urandom_range(1, 1300)), GRAY_MIN, GRAY_MAX);
				end
				CURVE_JAGGED: pts[i] = int'($urandom_range(0, 65535)) + GRAY_MIN;
				default: pts[i] = (i == POINTS - 1) ? GRAY_MAX : GRAY_MIN + 1337 * i;
			endcase
			rnd = $urandom();
			r.op    = OP_LOAD;
			r.idx   = i[5:0];
			r.pval  = GW'(pts[i]);
			r.gray  = rnd[15:0];
			r.scene = rnd[31:8];
			r.add   = rnd[23:0];
			send_req(r, 1'b0, none);
		end
	endtask

	// Pause the sender until every result is back, then let the core settle
	task automatic drain_core();
		in_valid <= 1'b0;
		while (expected_temps.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stall pattern
	initial begin : drive_out_stall
		int hold_cnt, open_cnt;
		hold_cnt = 0;
		open_cnt = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cnt == 0 && open_cnt == 0) begin
				hold_cnt = gap_len();
				open_cnt = $urandom_range(1, 30);
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				open_cnt--;
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin : check_results
		temp_res_t e;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_temps.size() == 0) begin
				$error("temperature_q8: expected no result, got %0d (status %0d)",
					temperature_q8, status);
				mismatches++;
			end else begin
				e = expected_temps.pop_front();
				if (temperature_q8 !== e.temp) begin
					$error("temperature_q8: expected %0d, got %0d", e.temp, temperature_q8);
					mismatches++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					mismatches++;
				end
			end
		end
	end

	// End the run once nothing has been taken for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		dir_row_t  rows [$];
		conv_req_t r;
		temp_res_t none;
		bit [31:0] rnd;
		int        pick, s, lo, hi, v, sens, ph;
		curve_t    kind;

		none.temp = '0;
		none.st   = ST_IN_TABLE;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		op           <= OP_LOAD;
		point_index  <= '0;
		point_value  <= '0;
		gray         <= '0;
		scene_offset <= '0;
		add_offset   <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// baseline table: point i sits at gray 100*i, sensor temperature still 0
		load_table(CURVE_BASELINE);
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, 0, 0, 1'b1, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MIN, 0, 0, 1'b1, -83886, ST_CLAMP_LO));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MAX, 0, 0, 1'b1, 83883, ST_CLAMP_HI));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 4900, 0, 0, 1'b1, 12544, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 150, 0, 0, 1'b0, 0, ST_IN_TABLE));
		// offset extremes drive the adjusted gray to its limits
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, OFS_MIN, OFS_MAX, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, OFS_MAX, OFS_MIN, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MIN, OFS_MIN, OFS_MIN, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MAX, OFS_MAX, OFS_MAX, 1'b0, 0, ST_IN_TABLE));
		// loads past the table end are dropped
		rows.push_back(mk_row(OP_LOAD, 63, GRAY_MIN, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_LOAD, POINTS, GRAY_MAX, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 4900, 0, 0, 1'b1, 12544, ST_IN_TABLE));
		// zero-width first segment
		rows.push_back(mk_row(OP_LOAD, 1, 0, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, 0, 0, 1'b1, 0, ST_NO_SEG));
		// falling first segment, reached through the low clamp
		rows.push_back(mk_row(OP_LOAD, 1, -100, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, -50, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, -50, 0, OFS_MIN, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_LOAD, 1, 100, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		// table ends at the gray extremes
		rows.push_back(mk_row(OP_LOAD, POINTS - 1, GRAY_MAX, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MAX, 0, 0, 1'b1, 12544, ST_IN_TABLE));
		rows.push_back(mk_row(OP_LOAD, 0, GRAY_MIN, 0, 0, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, GRAY_MIN, 0, 0, 1'b1, 0, ST_IN_TABLE));
		// adjustment truncates toward zero
		rows.push_back(mk_row(OP_CONVERT, 0, 0, 4850, 127, 0, 1'b0, 0, ST_IN_TABLE));
		rows.push_back(mk_row(OP_CONVERT, 0, 0, -1, -129, OFS_MAX, 1'b0, 0, ST_IN_TABLE));
		foreach (rows[k])
			send_req(rows[k].req, rows[k].fixed, rows[k].res);

		// random phases, each with its own sensor temperature and curve
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin sens = OFS_MIN; kind = CURVE_FULL_SPAN; end
				1: begin sens = OFS_MAX; kind = CURVE_LINEAR; end
				2: begin sens = 0; kind = CURVE_STAIRS; end
				3: begin sens = int'($urandom_range(0, 16777215)) + OFS_MIN; kind = CURVE_JAGGED; end
				4: begin sens = int'($urandom_range(0, 16777215)) + OFS_MIN; kind = CURVE_FALLING; end
				default: begin sens = int'($urandom_range(0, 4095)) - 2048; kind = CURVE_FINE; end
			endcase
			drain_core();
			// write the sensor temperature while the core is idle
			cfg_data  <= OW'(sens);
			cfg_valid <= 1'b1;
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sensor_copy = sens;
			@(negedge clk);
			cfg_valid <= 1'b0;
			calm = (ph == 2 || ph == 5);
			load_table(kind);

			repeat (PHASE_REQS) begin
				rnd = $urandom();
				r.op   = OP_CONVERT;
				r.idx  = rnd[5:0];
				r.pval = rnd[21:6];
				r.gray = rnd[31:16];
				rnd = $urandom();
				r.scene = rnd[23:0];
				rnd = $urandom();
				r.add = rnd[23:0];
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					// point update, mostly to an existing point, at times a small nudge of it
					r.op = OP_LOAD;
					if ($urandom_range(0, 4) != 0) begin
						r.idx = 6'($urandom_range(0, POINTS - 1));
						if ($urandom_range(0, 1) != 0)
							r.pval = GW'(clip(int'(cal_copy[r.idx]) +
								int'($urandom_range(0, 400)) - 200, GRAY_MIN, GRAY_MAX));
					end
				end else begin
					// keep the adjustment small most of the time
					if ($urandom_range(0, 9) < 7)
						r.scene = OW'(clip(sens + int'($urandom_range(0, 2047)) - 1024,
							OFS_MIN, OFS_MAX));
					if ($urandom_range(0, 9) < 6)
						r.add = OW'(int'($urandom_range(0, 8191)) - 4096);
					pick = $urandom_range(0, 99);
					if (pick < 70) begin
						s  = $urandom_range(0, POINTS - 2);
						lo = int'((cal_copy[s] < cal_copy[s+1]) ? cal_copy[s] : cal_copy[s+1]);
						hi = int'((cal_copy[s] < cal_copy[s+1]) ? cal_copy[s+1] : cal_copy[s]);
						r.gray = GW'(lo + int'($urandom_range(0, hi - lo)));
					end else if (pick < 85) begin
						if (pick < 78)
							v = int'(cal_copy[0]) - int'($urandom_range(0, 300));
						else
							v = int'(cal_copy[POINTS-1]) + int'($urandom_range(0, 300));
						r.gray = GW'(clip(v, GRAY_MIN, GRAY_MAX));
					end
				end
				send_req(r, 1'b0, none);
			end
		end

		drain_core();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/plgt_pkg.sv
rtl/plgt_ram.sv
rtl/plgt_div.sv
rtl/piecewise_linear_gray_to_temperature_core.sv
test/tb.sv
